/* design/grouped_free_block_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grouped free block allocator
// Immediate-style wrappers around concurrent checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define GFBA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent (may be a sequence) implies consequent in the same cycle
`define GFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/gfba_pkg.sv */
// ----------------------------------------------------------------------------
// gfba_pkg
// Types, constants and codes shared by the grouped free block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

    localparam int BLK_NUM_W      = 11;
    localparam int GROUP_SIZE_DEF = 100;
    localparam int NUM_BLOCKS_DEF = 2048;
    localparam int QUEUE_DEPTH    = 2;
    // wide enough for a stack count at the largest group size
    localparam int CNT_MAX_W      = 9;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_FREE    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [BLK_NUM_W-1:0] blk_num;
    } in_item_t;

    typedef struct packed {
        logic [BLK_NUM_W-1:0] block_address;
        logic                 status;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_NOP
    } gfba_op_t;

    typedef struct packed {
        gfba_op_t             op;
        logic [BLK_NUM_W-1:0] blk;
    } gfba_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_LOAD,
        ST_SPILL
    } gfba_state_t;

    typedef struct packed {
        gfba_state_t          state;
        logic [CNT_MAX_W-1:0] count;
    } gfba_status_t;

endpackage

`default_nettype wire

/* design/gfba_front.sv */
// ----------------------------------------------------------------------------
// gfba_front
// Takes request items and sorts them into allocate, free and ignored frees.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_front #(
    parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  gfba_pkg::in_item_t       in_item,
    output logic                     cmd_valid,
    output gfba_pkg::gfba_cmd_t      cmd,
    input  wire logic                cmd_ready
);
    import gfba_pkg::*;

    logic blk_bad;

    // block 0 is the end-of-list mark and cannot be freed
    assign blk_bad = (in_item.blk_num == '0) ||
                     (32'(in_item.blk_num) >= NUM_BLOCKS);

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb
    begin
        cmd.blk = in_item.blk_num;
        if (in_item.mode == MODE_ALLOC)
        begin
            cmd.op = OP_ALLOC;
        end
        else if (blk_bad)
        begin
            cmd.op = OP_NOP;
        end
        else
        begin
            cmd.op = OP_FREE;
        end
    end

endmodule

`default_nettype wire

/* design/gfba_cmd_queue.sv */
// ----------------------------------------------------------------------------
// gfba_cmd_queue
// Short queue of sorted commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_cmd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  gfba_pkg::gfba_cmd_t      push_cmd,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output gfba_pkg::gfba_cmd_t      pop_cmd
);
    import gfba_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    gfba_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   level_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (level_reg != LVL_W'(QUEUE_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/gfba_back.sv */
// ----------------------------------------------------------------------------
// gfba_back
// Carries out commands on the active stack and the group store, and holds
// the result register that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_back #(
    parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
    parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  gfba_pkg::gfba_cmd_t      cmd,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output gfba_pkg::out_item_t      res,
    output gfba_pkg::gfba_status_t   status
);
    import gfba_pkg::*;

    localparam int IDX_W   = $clog2(GROUP_SIZE);
    localparam int CNT_W   = $clog2(GROUP_SIZE + 1);
    localparam int BLK_W   = ($clog2(NUM_BLOCKS) < BLK_NUM_W) ? $clog2(NUM_BLOCKS) : BLK_NUM_W;
    localparam int ST_AW   = BLK_W + IDX_W;
    localparam int ST_DEPTH = 2 ** ST_AW;

    // entry 0 of the stack lives in link_reg, the memory holds the rest
    logic [BLK_NUM_W-1:0] stack_mem [GROUP_SIZE];
    logic [BLK_NUM_W-1:0] store_mem [ST_DEPTH];
    logic [BLK_NUM_W-1:0] stack_rd_reg;
    logic [BLK_NUM_W-1:0] store_rd_reg;

    gfba_state_t          state_reg;
    gfba_state_t          state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [BLK_NUM_W-1:0] link_reg;
    logic [BLK_NUM_W-1:0] link_next;
    logic [BLK_NUM_W-1:0] blk_reg;
    logic [BLK_NUM_W-1:0] blk_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    out_item_t            res_reg;
    out_item_t            res_data;
    logic                 res_set;

    logic                 stack_we;
    logic [IDX_W-1:0]     stack_waddr;
    logic [BLK_NUM_W-1:0] stack_wdata;
    logic [IDX_W-1:0]     stack_raddr;
    logic                 store_we;
    logic [ST_AW-1:0]     store_waddr;
    logic [BLK_NUM_W-1:0] store_wdata;
    logic [ST_AW-1:0]     store_raddr;

    logic                 take;
    logic                 link_bad;
    logic [CNT_W-1:0]     count_dec;
    logic [CNT_W-1:0]     cnt_dec;

    assign take      = (state_reg == ST_IDLE) && cmd_valid && (!res_valid_reg || res_ready);
    assign cmd_ready = take;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign count_dec = count_reg - 1'b1;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign link_bad  = (link_reg == '0) || (32'(link_reg) >= NUM_BLOCKS);

    assign status.state = state_reg;
    assign status.count = CNT_MAX_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        link_next      = link_reg;
        blk_next       = blk_reg;
        res_set        = 1'b0;
        res_data       = '{block_address: '0, status: STATUS_OK};
        stack_we       = 1'b0;
        stack_waddr    = cnt_dec[IDX_W-1:0];
        stack_wdata    = store_rd_reg;
        stack_raddr    = cnt_reg[IDX_W-1:0];
        store_we       = 1'b0;
        store_waddr    = {blk_reg[BLK_W-1:0], cnt_dec[IDX_W-1:0]};
        store_wdata    = (cnt_dec == '0) ? link_reg : stack_rd_reg;
        store_raddr    = {blk_reg[BLK_W-1:0], cnt_reg[IDX_W-1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (cmd.op)
                        OP_ALLOC:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                stack_raddr = count_dec[IDX_W-1:0];
                                count_next  = count_dec;
                                state_next  = ST_POP;
                            end
                            else if (link_bad)
                            begin
                                res_set         = 1'b1;
                                res_data.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                blk_next   = link_reg;
                                cnt_next   = '0;
                                state_next = ST_LOAD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (count_reg < CNT_W'(GROUP_SIZE))
                            begin
                                stack_we    = 1'b1;
                                stack_waddr = count_reg[IDX_W-1:0];
                                stack_wdata = cmd.blk;
                                count_next  = count_reg + 1'b1;
                                res_set     = 1'b1;
                            end
                            else
                            begin
                                blk_next   = cmd.blk;
                                cnt_next   = '0;
                                state_next = ST_SPILL;
                            end
                        end
                        default:
                        begin
                            res_set = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                res_set                = 1'b1;
                res_data.block_address = stack_rd_reg;
                state_next             = ST_IDLE;
            end
            ST_LOAD:
            begin
                // read entry cnt, write back entry cnt-1 from last cycle's read
                if (cnt_reg != '0)
                begin
                    if (cnt_dec == '0)
                    begin
                        link_next = store_rd_reg;
                    end
                    else
                    begin
                        stack_we = 1'b1;
                    end
                end
                if (cnt_reg == CNT_W'(GROUP_SIZE))
                begin
                    count_next             = CNT_W'(GROUP_SIZE);
                    res_set                = 1'b1;
                    res_data.block_address = blk_reg;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SPILL:
            begin
                if (cnt_reg != '0)
                begin
                    store_we = 1'b1;
                end
                if (cnt_reg == CNT_W'(GROUP_SIZE))
                begin
                    link_next  = blk_reg;
                    count_next = CNT_W'(1);
                    res_set    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_set)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(1);
            cnt_reg       <= '0;
            link_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            link_reg      <= link_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (res_set)
        begin
            res_reg <= res_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rd_reg <= store_mem[store_raddr];
    end

endmodule

`default_nettype wire

/* design/grouped_free_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_unit
// Grouped free list of disk block numbers: allocate or free one block per
// request item, with one result item for every request.
//
// Input channel in_valid/in_ready/in_item: mode 0 allocates, mode 1 frees
// blk_num. Output channel out_valid/out_ready/out_item: the allocated
// block (0 on a free or when none is left) and status (1 = no free block).
// Requests pass through a two-entry command queue, so the block keeps
// taking items while a result waits on a stalled receiver; once the queue
// is full, in_ready drops until the back end drains a command.
// A push, an ignored free or an empty allocate finishes from idle; a pop
// passes through ST_POP; an allocate that loads a group or a free that
// spills the full stack copies the group one entry a cycle through the
// stack and group store, each with one read and one write port.
// The back end takes a command only in idle; later ones wait in the queue.
// Reset clears the stack to a lone zero link with count 1 (nothing free);
// the group store needs no clearing, it is only read where written.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_free_block_allocator_unit #(
    parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
    parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  gfba_pkg::in_item_t       in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gfba_pkg::out_item_t      out_item
);
    import gfba_pkg::*;

    logic         fr_valid;
    gfba_cmd_t    fr_cmd;
    logic         fr_ready;
    logic         q_valid;
    gfba_cmd_t    q_cmd;
    logic         q_ready;
    gfba_status_t bk_status;

    gfba_front #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (fr_valid),
        .cmd       (fr_cmd),
        .cmd_ready (fr_ready)
    );

    gfba_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    gfba_back #(
        .GROUP_SIZE (GROUP_SIZE),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (out_item),
        .status    (bk_status)
    );

`include "grouped_free_block_allocator_unit_assert.svh"

    `GFBA_ASSERT_ALWAYS(a_count_range,
        (bk_status.count >= CNT_MAX_W'(1)) && (bk_status.count <= CNT_MAX_W'(GROUP_SIZE)),
        "stack count out of range")
    `GFBA_ASSERT_IMPL(a_spill_restart,
        (bk_status.state == ST_SPILL) ##1 (bk_status.state == ST_IDLE),
        bk_status.count == CNT_MAX_W'(1), "spill did not restart the stack")
    `GFBA_ASSERT_IMPL(a_load_full,
        (bk_status.state == ST_LOAD) ##1 (bk_status.state == ST_IDLE),
        bk_status.count == CNT_MAX_W'(GROUP_SIZE), "group load did not fill the stack")
    `GFBA_ASSERT_IMPL(a_pop_result,
        (bk_status.state == ST_POP) ##1 1'b1, out_valid, "pop finished without a result")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: grouped free block allocator testbench
// Drives allocate and free requests through the valid/ready input channel.
// A tracking model of the free stack and the spilled groups predicts every
// result, which is checked field by field as it leaves the output channel.
// The random part alternates free-heavy and allocate-heavy runs, so the
// stack fills, spills into the group store and is reloaded from it.
// ----------------------------------------------------------------------------
module tb_top;
    import gfba_pkg::*;

    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = GROUP_SIZE_DEF + 10;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    bit        steady_run;

    class block_list_checker;
        logic [BLK_NUM_W-1:0] free_stack [GROUP_SIZE_DEF];
        int unsigned          free_count;
        logic [BLK_NUM_W-1:0] spilled_groups [int unsigned];
        out_item_t            expected_grants [$];
        int unsigned          fail_count;

        function new();
            foreach (free_stack[i])
                free_stack[i] = '0;
            free_count = 1;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return expected_grants.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            fail_count++;
        endtask

        function void note_request(in_item_t req);
            out_item_t   res;
            int unsigned link;
            int unsigned base;
            res.block_address = '0;
            res.status        = STATUS_OK;
            if (req.mode == MODE_ALLOC) begin
                if (free_count > 1) begin
                    free_count--;
                    res.block_address = free_stack[free_count];
                end else if (free_stack[0] == '0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    // last entry gone: hand out the link and reload its group
                    link = free_stack[0];
                    base = link * GROUP_SIZE_DEF;
                    res.block_address = BLK_NUM_W'(link);
                    for (int i = 0; i < GROUP_SIZE_DEF; i++)
                        free_stack[i] = spilled_groups[base + i];
                    free_count = GROUP_SIZE_DEF;
                end
            end else if (req.blk_num != '0 && req.blk_num < NUM_BLOCKS_DEF) begin
                if (free_count < GROUP_SIZE_DEF) begin
                    free_stack[free_count] = req.blk_num;
                    free_count++;
                end else begin
                    base = req.blk_num * GROUP_SIZE_DEF;
                    for (int i = 0; i < GROUP_SIZE_DEF; i++)
                        spilled_groups[base + i] = free_stack[i];
                    free_stack[0] = req.blk_num;
                    free_count = 1;
                end
            end
            expected_grants.push_back(res);
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result addr %0d status %0d",
                                          got.block_address, got.status));
                return;
            end
            want = expected_grants.pop_front();
            if (got.block_address !== want.block_address)
                report_mismatch($sformatf("block_address %0d, expected %0d",
                                          got.block_address, want.block_address));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
        endtask
    endclass

    block_list_checker sb = new();

    grouped_free_block_allocator_unit #(
        .GROUP_SIZE (GROUP_SIZE_DEF),
        .NUM_BLOCKS (NUM_BLOCKS_DEF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one; none in a steady run
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_request(input in_item_t req);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        sb.note_request(req);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    // receiver: random stalls, plus one long hold so the input backs up
    initial
    begin : receiver
        int unsigned taken;
        int unsigned gap;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
            gap = (taken == HOLD_AT) ? HOLD_CYCLES : pick_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : sender
        in_item_t    req;
        int unsigned sent;
        int unsigned seg;
        int unsigned seg_len;
        int unsigned free_pct;
        int unsigned pick;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        out_ready  <= 1'b0;
        steady_run = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, ignored free of block 0, bit patterns pushed and popped
        send_request(in_item_t'{MODE_ALLOC, 11'd0});
        send_request(in_item_t'{MODE_FREE,  11'd0});
        send_request(in_item_t'{MODE_ALLOC, 11'd2047});
        send_request(in_item_t'{MODE_FREE,  11'd2047});
        send_request(in_item_t'{MODE_FREE,  11'd1});
        send_request(in_item_t'{MODE_FREE,  11'd1024});
        send_request(in_item_t'{MODE_FREE,  11'd1365});
        send_request(in_item_t'{MODE_FREE,  11'd682});
        send_request(in_item_t'{MODE_FREE,  11'd0});
        send_request(in_item_t'{MODE_ALLOC, 11'd1365});
        send_request(in_item_t'{MODE_ALLOC, 11'd682});
        send_request(in_item_t'{MODE_ALLOC, 11'd0});
        send_request(in_item_t'{MODE_ALLOC, 11'd0});
        send_request(in_item_t'{MODE_ALLOC, 11'd0});
        send_request(in_item_t'{MODE_ALLOC, 11'd0});
        send_request(in_item_t'{MODE_FREE,  11'd5});
        send_request(in_item_t'{MODE_ALLOC, 11'd0});
        drain_results();

        // free-heavy runs fill and spill the stack, allocate-heavy runs
        // drain it through group reloads down to the empty list
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg % 2 == 0)
            begin
                seg_len  = $urandom_range(150, 220);
                free_pct = 92;
            end
            else
            begin
                seg_len  = $urandom_range(80, 180);
                free_pct = 12;
            end
            steady_run = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++)
            begin
                req.mode = ($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC;
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    req.blk_num = '0;
                else if (pick < 7)
                    req.blk_num = '1;
                else
                    req.blk_num = BLK_NUM_W'($urandom_range(1, NUM_BLOCKS_DEF - 1));
                send_request(req);
                sent++;
            end
            seg++;
            drain_results();
        end

        steady_run = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("PASS grouped_free_block_allocator_unit");
        else
            $display("FAIL grouped_free_block_allocator_unit");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("FAIL grouped_free_block_allocator_unit");
        $finish;
    end

endmodule
